FILE: rtl/core/ordered_key_value_table_macros.svh
// Assertion helpers used by the checker file.
`ifndef ORDERED_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OKVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OKVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/okvt_pkg.sv
`default_nettype none

package okvt_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int OP_BITS    = 3;
    localparam int POS_BITS   = 4;

    // Slave tdata: key, value, position (low to high), zero padded.
    localparam int IN_KEY_LSB    = 0;
    localparam int IN_VALUE_LSB  = IN_KEY_LSB + KEY_BITS;
    localparam int IN_POS_LSB    = IN_VALUE_LSB + VALUE_BITS;
    localparam int IN_FIELD_BITS = IN_POS_LSB + POS_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_PAD_BITS   = IN_DATA_BITS - IN_FIELD_BITS;

    // Master tdata: success, key, value, count, full (low to high), zero padded.
    localparam int OUT_SUCCESS_LSB = 0;
    localparam int OUT_KEY_LSB     = OUT_SUCCESS_LSB + 1;
    localparam int OUT_VALUE_LSB   = OUT_KEY_LSB + KEY_BITS;
    localparam int OUT_COUNT_LSB   = OUT_VALUE_LSB + VALUE_BITS;
    localparam int OUT_FULL_LSB    = OUT_COUNT_LSB + CNT_BITS;
    localparam int OUT_FIELD_BITS  = OUT_FULL_LSB + 1;
    localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS    = OUT_DATA_BITS - OUT_FIELD_BITS;

    localparam logic [OP_BITS-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_BITS-1:0] OP_UPDATE     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_UPSERT     = 3'd2;
    localparam logic [OP_BITS-1:0] OP_ERASE      = 3'd3;
    localparam logic [OP_BITS-1:0] OP_LOOKUP     = 3'd4;
    localparam logic [OP_BITS-1:0] OP_READ_POS   = 3'd5;

    // Per-cycle command broadcast along the cell chain.
    typedef struct packed {
        logic push;    // every cell takes its upstream neighbor, cell 0 the request
        logic update;  // matching cell takes the request value
        logic erase;   // cells at or past the match take their downstream neighbor
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/okvt_cell.sv
`default_nettype none

module okvt_cell (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 load_match,
    input  wire [okvt_pkg::KEY_BITS-1:0]        cmp_key,
    input  wire                                 occupied,
    input  wire okvt_pkg::cell_cmd_t            cmd,
    input  wire                                 prefix_in,
    input  wire [okvt_pkg::KEY_BITS-1:0]        up_key,
    input  wire [okvt_pkg::VALUE_BITS-1:0]      up_value,
    input  wire [okvt_pkg::KEY_BITS-1:0]        dn_key,
    input  wire [okvt_pkg::VALUE_BITS-1:0]      dn_value,
    input  wire [okvt_pkg::VALUE_BITS-1:0]      new_value,
    output logic [okvt_pkg::KEY_BITS-1:0]       cur_key,
    output logic [okvt_pkg::VALUE_BITS-1:0]     cur_value,
    output logic                                match,
    output logic                                prefix_out
);

    logic [okvt_pkg::KEY_BITS-1:0]   key_reg;
    logic [okvt_pkg::KEY_BITS-1:0]   key_next;
    logic [okvt_pkg::VALUE_BITS-1:0] value_reg;
    logic [okvt_pkg::VALUE_BITS-1:0] value_next;
    logic                            match_reg;
    logic                            match_next;
    logic                            shift;

    // Set at the matching cell and every cell below it.
    assign shift      = prefix_in | match_reg;
    assign prefix_out = shift;

    always_comb
    begin
        match_next = load_match ? (occupied && (cmp_key == key_reg)) : match_reg;
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        priority if (cmd.push)
        begin
            key_next   = up_key;
            value_next = up_value;
        end
        else if (cmd.erase && shift)
        begin
            key_next   = dn_key;
            value_next = dn_value;
        end
        else if (cmd.update && match_reg)
        begin
            value_next = new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign cur_key   = key_reg;
    assign cur_value = value_reg;
    assign match     = match_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ordered_key_value_table.sv
// Ordered key/value table, newest entry at position 0, up to 16 unique keys.
// Entries live in a row of cells; each request is handled in the IDLE and EXEC
// states: in the cycle it is accepted every cell compares its key with the
// request key, and in EXEC the row shifts down (insert), shifts up from the
// match (erase) or rewrites the matching value (update), and the response is
// registered. EXEC waits while the previous response has not been taken, and
// no new request is taken until EXEC ends. The response register lets a new
// request in while a response is pending. No clearing pass after reset: the
// entry count alone says which cells are live.
`default_nettype none

module ordered_key_value_table (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire [okvt_pkg::IN_DATA_BITS-1:0]        s_tdata,   // item_key, item_value, position
    input  wire [okvt_pkg::OP_BITS-1:0]             s_tuser,   // operation
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [okvt_pkg::OUT_DATA_BITS-1:0]      m_tdata    // success, found_key,
                                                               // found_value, entry_count,
                                                               // table_full
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam int CAP      = okvt_pkg::CAPACITY;
    localparam int KB       = okvt_pkg::KEY_BITS;
    localparam int VB       = okvt_pkg::VALUE_BITS;
    localparam int CB       = okvt_pkg::CNT_BITS;

    logic                          state_reg;
    logic                          state_next;
    logic [okvt_pkg::OP_BITS-1:0]  req_op_reg;
    logic [KB-1:0]                 req_key_reg;
    logic [VB-1:0]                 req_value_reg;
    logic [okvt_pkg::POS_BITS-1:0] req_pos_reg;
    logic [CB-1:0]                 count_reg;
    logic [CB-1:0]                 count_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_success_reg;
    logic [KB-1:0]                 out_key_reg;
    logic [VB-1:0]                 out_value_reg;
    logic [CB-1:0]                 out_count_reg;
    logic                          out_full_reg;

    logic                          accept;
    logic                          commit;
    logic [KB-1:0]                 in_key;

    logic [KB-1:0]                 cell_key   [CAP];
    logic [VB-1:0]                 cell_value [CAP];
    logic [CAP-1:0]                cell_match;
    logic [CAP-1:0]                cell_occ;
    logic [CAP:0]                  prefix;

    okvt_pkg::cell_cmd_t           cmd;
    okvt_pkg::cell_cmd_t           cmd_gated;
    logic                          hit;
    logic                          is_full;
    logic                          pos_ok;
    logic [VB-1:0]                 hit_value;
    logic                          res_success;
    logic [KB-1:0]                 res_key;
    logic [VB-1:0]                 res_value;
    logic                          res_full;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign in_key   = s_tdata[okvt_pkg::IN_KEY_LSB +: KB];

    assign prefix[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            logic [KB-1:0] up_key;
            logic [VB-1:0] up_value;
            logic [KB-1:0] dn_key;
            logic [VB-1:0] dn_value;

            assign cell_occ[gi] = (count_reg > CB'(gi));

            if (gi == 0)
            begin : g_head
                assign up_key   = req_key_reg;
                assign up_value = req_value_reg;
            end
            else
            begin : g_body
                assign up_key   = cell_key[gi-1];
                assign up_value = cell_value[gi-1];
            end

            if (gi == CAP - 1)
            begin : g_tail
                assign dn_key   = cell_key[gi];
                assign dn_value = cell_value[gi];
            end
            else
            begin : g_link
                assign dn_key   = cell_key[gi+1];
                assign dn_value = cell_value[gi+1];
            end

            okvt_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .load_match (accept),
                .cmp_key    (in_key),
                .occupied   (cell_occ[gi]),
                .cmd        (cmd_gated),
                .prefix_in  (prefix[gi]),
                .up_key     (up_key),
                .up_value   (up_value),
                .dn_key     (dn_key),
                .dn_value   (dn_value),
                .new_value  (req_value_reg),
                .cur_key    (cell_key[gi]),
                .cur_value  (cell_value[gi]),
                .match      (cell_match[gi]),
                .prefix_out (prefix[gi+1])
            );
        end
    endgenerate

    assign hit     = |cell_match;
    assign is_full = (count_reg == CB'(CAP));
    assign pos_ok  = (CB'(req_pos_reg) < count_reg);

    // Keys are unique, so at most one cell matches.
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < CAP; i++)
        begin
            hit_value = hit_value | ({VB{cell_match[i]}} & cell_value[i]);
        end
    end

    always_comb
    begin
        cmd         = '0;
        res_success = 1'b0;
        res_key     = '0;
        res_value   = '0;
        res_full    = 1'b0;
        count_next  = count_reg;
        unique case (req_op_reg)
            okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT:
            begin
                if (hit)
                begin
                    if (req_op_reg == okvt_pkg::OP_UPSERT)
                    begin
                        cmd.update  = 1'b1;
                        res_success = 1'b1;
                        res_key     = req_key_reg;
                        res_value   = req_value_reg;
                    end
                end
                else if (is_full)
                begin
                    res_full = 1'b1;
                end
                else
                begin
                    cmd.push    = 1'b1;
                    res_success = 1'b1;
                    res_key     = req_key_reg;
                    res_value   = req_value_reg;
                    count_next  = count_reg + CB'(1);
                end
            end
            okvt_pkg::OP_UPDATE:
            begin
                if (hit)
                begin
                    cmd.update  = 1'b1;
                    res_success = 1'b1;
                    res_key     = req_key_reg;
                    res_value   = req_value_reg;
                end
            end
            okvt_pkg::OP_ERASE:
            begin
                if (hit)
                begin
                    cmd.erase   = 1'b1;
                    res_success = 1'b1;
                    res_key     = req_key_reg;
                    res_value   = hit_value;
                    count_next  = count_reg - CB'(1);
                end
            end
            okvt_pkg::OP_LOOKUP:
            begin
                if (hit)
                begin
                    res_success = 1'b1;
                    res_key     = req_key_reg;
                    res_value   = hit_value;
                end
            end
            okvt_pkg::OP_READ_POS:
            begin
                if (pos_ok)
                begin
                    res_success = 1'b1;
                    res_key     = cell_key[req_pos_reg[okvt_pkg::IDX_BITS-1:0]];
                    res_value   = cell_value[req_pos_reg[okvt_pkg::IDX_BITS-1:0]];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_gated = commit ? cmd : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg    <= s_tuser;
            req_key_reg   <= in_key;
            req_value_reg <= s_tdata[okvt_pkg::IN_VALUE_LSB +: VB];
            req_pos_reg   <= s_tdata[okvt_pkg::IN_POS_LSB +: okvt_pkg::POS_BITS];
        end
        if (commit)
        begin
            out_success_reg <= res_success;
            out_key_reg     <= res_key;
            out_value_reg   <= res_value;
            out_count_reg   <= count_next;
            out_full_reg    <= res_full;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{okvt_pkg::OUT_PAD_BITS{1'b0}}, out_full_reg, out_count_reg,
                       out_value_reg, out_key_reg, out_success_reg};

endmodule

`default_nettype wire

FILE: rtl/core/okvt_checker.sv
`default_nettype none
`include "ordered_key_value_table_macros.svh"

module okvt_checker (
    input wire                                  clk,
    input wire                                  rst_n,
    input wire                                  s_tvalid,
    input wire                                  s_tready,
    input wire [okvt_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input wire [okvt_pkg::OP_BITS-1:0]          s_tuser,
    input wire                                  m_tvalid,
    input wire                                  m_tready,
    input wire [okvt_pkg::OUT_DATA_BITS-1:0]    m_tdata
);

    logic                          rsp_success;
    logic                          rsp_full;
    logic [okvt_pkg::CNT_BITS-1:0] rsp_count;
    logic                          req_seen;

    assign rsp_success = m_tdata[okvt_pkg::OUT_SUCCESS_LSB];
    assign rsp_full    = m_tdata[okvt_pkg::OUT_FULL_LSB];
    assign rsp_count   = m_tdata[okvt_pkg::OUT_COUNT_LSB +: okvt_pkg::CNT_BITS];
    assign req_seen    = s_tvalid && s_tready;

    `OKVT_ASSERT_NEXT(a_rsp_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "response changed while stalled")

    `OKVT_ASSERT_NEXT(a_one_at_a_time, req_seen, !s_tready,
        "new transaction taken while one is in progress")

    `OKVT_ASSERT_NOW(a_count_range, m_tvalid,
        rsp_count <= okvt_pkg::CNT_BITS'(okvt_pkg::CAPACITY),
        "entry count above capacity")

    `OKVT_ASSERT_NOW(a_full_is_fail, m_tvalid && rsp_full,
        !rsp_success && (rsp_count == okvt_pkg::CNT_BITS'(okvt_pkg::CAPACITY)),
        "full flag without a full, refused request")

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (.*);

`default_nettype wire

FILE: dv/ordered_key_value_table_check.sv
`timescale 1ns / 100ps

module ordered_key_value_table_check (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    input  wire [okvt_pkg::IN_DATA_BITS-1:0]    s_tdata,   // item_key, item_value, position
    input  wire [okvt_pkg::OP_BITS-1:0]         s_tuser,   // operation
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    input  wire [okvt_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // success, found_key,
                                                           // found_value, entry_count,
                                                           // table_full
    output int                                  fail_count,
    output int                                  pending
);
    import okvt_pkg::*;

    typedef struct packed {
        logic                  success;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_BITS-1:0]   count;
        logic                  full;
    } table_reply_t;

    // Shadow copy of the table, newest entry at index 0
    logic [KEY_BITS-1:0]   key_row   [CAPACITY];
    logic [VALUE_BITS-1:0] value_row [CAPACITY];
    int                    live = 0;

    table_reply_t replies_due [$];
    table_reply_t want;
    table_reply_t got;
    int           errors = 0;

    assign fail_count = errors;

    function automatic int locate_key(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < live; i++)
        begin
            if (key_row[i] == key)
                return i;
        end
        return -1;
    endfunction

    function automatic table_reply_t serve_request(logic [OP_BITS-1:0]    op,
                                                   logic [KEY_BITS-1:0]   key,
                                                   logic [VALUE_BITS-1:0] value,
                                                   logic [POS_BITS-1:0]   pos);
        table_reply_t r;
        int           at;
        r  = '0;
        at = locate_key(key);
        case (op)
            OP_INSERT, OP_UPSERT:
            begin
                if (at >= 0)
                begin
                    // plain insert refuses a duplicate without raising full
                    if (op == OP_UPSERT)
                    begin
                        value_row[at] = value;
                        r.success = 1'b1;
                        r.key     = key;
                        r.value   = value;
                    end
                end
                else if (live >= CAPACITY)
                begin
                    r.full = 1'b1;
                end
                else
                begin
                    for (int i = live; i > 0; i--)
                    begin
                        key_row[i]   = key_row[i-1];
                        value_row[i] = value_row[i-1];
                    end
                    key_row[0]   = key;
                    value_row[0] = value;
                    live++;
                    r.success = 1'b1;
                    r.key     = key;
                    r.value   = value;
                end
            end
            OP_UPDATE:
            begin
                if (at >= 0)
                begin
                    value_row[at] = value;
                    r.success = 1'b1;
                    r.key     = key;
                    r.value   = value;
                end
            end
            OP_ERASE:
            begin
                if (at >= 0)
                begin
                    r.success = 1'b1;
                    r.key     = key;
                    r.value   = value_row[at];
                    // close the gap, order of the rest kept
                    for (int i = at; i + 1 < live; i++)
                    begin
                        key_row[i]   = key_row[i+1];
                        value_row[i] = value_row[i+1];
                    end
                    live--;
                end
            end
            OP_LOOKUP:
            begin
                if (at >= 0)
                begin
                    r.success = 1'b1;
                    r.key     = key;
                    r.value   = value_row[at];
                end
            end
            OP_READ_POS:
            begin
                if (pos < live)
                begin
                    r.success = 1'b1;
                    r.key     = key_row[pos];
                    r.value   = value_row[pos];
                end
            end
            default:
            begin
                // spare codes: no effect, request fails
            end
        endcase
        r.count = CNT_BITS'(live);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live = 0;
            replies_due.delete();
        end
        else
        begin
            // response side first so a stray response is never masked
            if (m_tvalid && m_tready)
            begin
                got.success = m_tdata[OUT_SUCCESS_LSB];
                got.key     = m_tdata[OUT_KEY_LSB +: KEY_BITS];
                got.value   = m_tdata[OUT_VALUE_LSB +: VALUE_BITS];
                got.count   = m_tdata[OUT_COUNT_LSB +: CNT_BITS];
                got.full    = m_tdata[OUT_FULL_LSB];
                if (replies_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: response transaction expected none, actual %0h",
                             $time, m_tdata);
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("success", 64'(want.success), 64'(got.success));
                    check_field("found_key", 64'(want.key), 64'(got.key));
                    check_field("found_value", 64'(want.value), 64'(got.value));
                    check_field("entry_count", 64'(want.count), 64'(got.count));
                    check_field("table_full", 64'(want.full), 64'(got.full));
                end
            end
            if (s_tvalid && s_tready)
            begin
                replies_due.push_back(serve_request(s_tuser,
                                                    s_tdata[IN_KEY_LSB +: KEY_BITS],
                                                    s_tdata[IN_VALUE_LSB +: VALUE_BITS],
                                                    s_tdata[IN_POS_LSB +: POS_BITS]));
            end
        end
        pending <= replies_due.size();
    end

endmodule

FILE: dv/ordered_key_value_table_test.sv
`timescale 1ns / 100ps

module ordered_key_value_table_test;
    import okvt_pkg::*;

    // codes the block leaves unused
    localparam logic [OP_BITS-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_HI = 3'd7;
    localparam int KEY_POOL    = 22;
    localparam int PHASE_ITEMS = 310;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    wire                      s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [OP_BITS-1:0]       s_tuser  = '0;
    wire                      m_tvalid;
    logic                     m_tready = 1'b0;
    wire  [OUT_DATA_BITS-1:0] m_tdata;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_plan  [4] = '{0, 76, 0, 23};
    int stall_plan [4] = '{0, 0, 76, 23};

    logic [KEY_BITS-1:0] key_pool [KEY_POOL];

    ordered_key_value_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ordered_key_value_table_check table_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_request(logic [OP_BITS-1:0]    op,
                                logic [KEY_BITS-1:0]   key,
                                logic [VALUE_BITS-1:0] value,
                                logic [POS_BITS-1:0]   pos);
        logic [IN_DATA_BITS-1:0] word;
        word = '0;
        word[IN_KEY_LSB +: KEY_BITS]     = key;
        word[IN_VALUE_LSB +: VALUE_BITS] = value;
        word[IN_POS_LSB +: POS_BITS]     = pos;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // grow phases favor inserts so the table reaches full; others drain it
    task automatic send_random(bit grow);
        int                  pick;
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] key;
        pick = $urandom_range(99);
        if (pick < (grow ? 30 : 10))
            op = OP_INSERT;
        else if (pick < (grow ? 45 : 15))
            op = OP_UPSERT;
        else if (pick < (grow ? 55 : 25))
            op = OP_UPDATE;
        else if (pick < (grow ? 65 : 60))
            op = OP_ERASE;
        else if (pick < (grow ? 80 : 78))
            op = OP_LOOKUP;
        else if (pick < 97)
            op = OP_READ_POS;
        else
            op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
        if ($urandom_range(9) == 0)
            key = $urandom;
        else
            key = key_pool[$urandom_range(KEY_POOL - 1)];
        send_request(op, key, $urandom, POS_BITS'($urandom_range(15)));
    endtask

    initial
    begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // misses on an empty table, then inserts, upserts and the spare codes
        send_request(OP_READ_POS, '0, '0, '0);
        send_request(OP_LOOKUP, 32'h5, '0, '0);
        send_request(OP_UPDATE, 32'h5, 32'h1, '0);
        send_request(OP_ERASE, 32'h5, '0, '0);
        send_request(OP_INSERT, '0, '1, '0);
        send_request(OP_INSERT, '1, '0, '1);
        send_request(OP_INSERT, '0, 32'h1234_5678, '0);   // duplicate, refused
        send_request(OP_UPSERT, '0, 32'hA5A5_5A5A, '0);
        send_request(OP_UPSERT, 32'h7, 32'h7777_7777, '0);
        send_request(OP_SPARE_LO, '1, '1, '1);
        send_request(OP_SPARE_HI, '1, '1, '1);
        // 13 fit, the last one hits a full table
        for (int i = 0; i < 14; i++)
            send_request(OP_INSERT, 32'h100 + i, $urandom, '0);
        send_request(OP_UPSERT, 32'hDEAD_BEEF, '1, '0);  // absent key, table full
        send_request(OP_READ_POS, '0, '0, '1);
        send_request(OP_ERASE, 32'h7, '0, '0);           // gap mid-table
        send_request(OP_LOOKUP, '1, '0, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_plan[phase];
            stall_pct    <= stall_plan[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(((n / 40) % 2) == 0);
        end

        s_tvalid <= 1'b0;
        stall_pct <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
